// ===== rtl/stqf_pkg.sv =====
// Package for the sorted type/qualifier filter: request and response payloads,
// opcode and status codes, controller states and controller/datapath buses.
// No dependencies.
package stqf_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADTYPE = 2'd3;

    localparam int KEY_W = 24;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  type_code;
        logic [15:0] qualifier;
    } req_t;

    typedef struct packed {
        logic       keep;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_CMP,
        S_CHK_P,
        S_CAP_P,
        S_CHK_PM1,
        S_CAP_PM1,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_WR,
        S_INSERT,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_MID,
        RD_P,
        RD_PM1,
        RD_SHIFT
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       clear;
        rd_sel_t    rd_sel;
        logic       search_upd;
        logic       cap_p;
        logic       cap_pm1;
        logic       shift_init;
        logic       shift_wr;
        logic       ins_wr;
        logic       out_load;
        logic       out_keep;
        logic [1:0] out_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic search_done;
        logic p_lt_count;
        logic p_nonzero;
        logic full;
        logic shift_done;
        logic eq;
        logic p_type;
        logic pm1_type;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/stqf_datapath.sv =====
// Datapath of the sorted type/qualifier filter: rule memory, search bounds,
// shift pointer, compare flags and the response register. Uses stqf_pkg.
module stqf_datapath
    import stqf_pkg::*;
#(
    parameter int MAX_RULES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [KEY_W-1:0] mem [MAX_RULES];

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] rd_data_reg;
    logic             eq_reg, p_type_reg, pm1_type_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [CW-1:0]    mid;
    logic [CW-1:0]    rd_addr;
    logic [CW-1:0]    wr_addr;
    logic             rd_en;
    logic             wr_en;
    logic [KEY_W-1:0] wr_data;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_MID:   rd_addr = mid;
            RD_P:     rd_addr = lo_reg;
            RD_PM1:   rd_addr = lo_reg - CW'(1);
            RD_SHIFT: rd_addr = ptr_reg - CW'(1);
            default:  rd_addr = '0;
        endcase
    end

    assign rd_en   = (cmd.rd_sel != RD_NONE);
    assign wr_en   = cmd.shift_wr || cmd.ins_wr;
    assign wr_addr = cmd.ins_wr ? lo_reg : ptr_reg;
    assign wr_data = cmd.ins_wr ? key_reg : rd_data_reg;

    // Rule memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ptr_next   = ptr_reg;
        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.search_upd)
        begin
            if (rd_data_reg < key_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.shift_init)
        begin
            ptr_next = count_reg;
        end
        if (cmd.shift_wr)
        begin
            ptr_next = ptr_reg - CW'(1);
        end
        if (cmd.ins_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            key_reg      <= {req.type_code, req.qualifier};
            eq_reg       <= 1'b0;
            p_type_reg   <= 1'b0;
            pm1_type_reg <= 1'b0;
        end
        if (cmd.cap_p)
        begin
            eq_reg     <= (rd_data_reg == key_reg);
            p_type_reg <= (rd_data_reg[23:16] == key_reg[23:16]);
        end
        if (cmd.cap_pm1)
        begin
            pm1_type_reg <= (rd_data_reg[23:16] == key_reg[23:16]);
        end
        if (cmd.out_load)
        begin
            rsp_reg.keep   <= cmd.out_keep;
            rsp_reg.status <= cmd.out_status;
        end
    end

    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.p_lt_count  = (lo_reg < count_reg);
    assign sts.p_nonzero   = (lo_reg != '0);
    assign sts.full        = (count_reg == CW'(MAX_RULES));
    assign sts.shift_done  = (ptr_reg == lo_reg);
    assign sts.eq          = eq_reg;
    assign sts.p_type      = p_type_reg;
    assign sts.pm1_type    = pm1_type_reg;
    assign sts.out_free    = !(rsp_valid_reg && rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count above table size");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("response loaded over a stalled response");
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> (count_reg < CW'(MAX_RULES)))
        else $error("insert into a full table");
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (ptr_reg > lo_reg) && (ptr_reg <= count_reg))
        else $error("shift pointer out of range");
`endif

endmodule

// ===== rtl/stqf_ctrl.sv =====
// Controller of the sorted type/qualifier filter: sequences search, neighbor
// checks, shift-insert and the response. Uses stqf_pkg.
module stqf_ctrl
    import stqf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       keep_reg, keep_next;
    logic [1:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_ADD;
            keep_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            keep_reg   <= keep_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        keep_next   = keep_reg;
        status_next = status_reg;
        req_stall   = 1'b1;

        cmd.load       = 1'b0;
        cmd.clear      = 1'b0;
        cmd.rd_sel     = RD_NONE;
        cmd.search_upd = 1'b0;
        cmd.cap_p      = 1'b0;
        cmd.cap_pm1    = 1'b0;
        cmd.shift_init = 1'b0;
        cmd.shift_wr   = 1'b0;
        cmd.ins_wr     = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.out_keep   = keep_reg;
        cmd.out_status = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    op_next     = req.opcode;
                    keep_next   = 1'b0;
                    status_next = ST_OK;
                    if (req.opcode == OP_ADD)
                    begin
                        if (req.type_code == 8'd0)
                        begin
                            status_next = ST_BADTYPE;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    else if (req.opcode == OP_TEST)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        cmd.clear  = (req.opcode == OP_CLEAR);
                        state_next = S_RESP;
                    end
                end
            end
            S_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = S_CHK_P;
                end
                else
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                cmd.search_upd = 1'b1;
                state_next     = S_SEARCH;
            end
            S_CHK_P:
            begin
                if (sts.p_lt_count)
                begin
                    cmd.rd_sel = RD_P;
                    state_next = S_CAP_P;
                end
                else
                begin
                    state_next = S_CHK_PM1;
                end
            end
            S_CAP_P:
            begin
                cmd.cap_p  = 1'b1;
                state_next = S_CHK_PM1;
            end
            S_CHK_PM1:
            begin
                if ((op_reg == OP_TEST) && sts.p_nonzero)
                begin
                    cmd.rd_sel = RD_PM1;
                    state_next = S_CAP_PM1;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_CAP_PM1:
            begin
                cmd.cap_pm1 = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (op_reg == OP_TEST)
                begin
                    keep_next  = sts.eq || !(sts.p_type || sts.pm1_type);
                    state_next = S_RESP;
                end
                else if (sts.eq)
                begin
                    status_next = ST_PRESENT;
                    state_next  = S_RESP;
                end
                else if (sts.full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.rd_sel = RD_SHIFT;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT;
            end
            S_INSERT:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request left controller idle");
    a_one_response: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("response issued outside response step");
    a_insert_add: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> (op_reg == OP_ADD) && (status_reg == ST_OK))
        else $error("insert for a request that is not a valid add");
`endif

endmodule

// ===== rtl/sorted_type_qualifier_filter_core.sv =====
// Sorted type/qualifier filter core (stqf_pkg, stqf_ctrl, stqf_datapath); one request at a time.
// Clear, the unused opcode and a bad-type add go straight to the response; test and add run a
// binary search (up to ceil(log2(N+1)) steps over N rules), then neighbor checks; an add that
// is not a duplicate and finds room shifts each rule above the insert point, then inserts.
// Takes the next request in the cycle after the response loads, which waits while a stalled
// response holds the output register. Reset empties the table at once (rule count to zero).
module sorted_type_qualifier_filter_core
    import stqf_pkg::*;
#(
    parameter int MAX_RULES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    // Request channel
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    // Response channel
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Command and status buses between the sequencer and the datapath
    cmd_t cmd;
    sts_t sts;

    // Controller: takes a request only when idle, then walks the binary
    // search, the neighbor checks and, for an insert, the shift sweep.
    stqf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: rule memory, search bounds, compare flags and the response
    // register, which holds a finished response while the consumer stalls.
    stqf_datapath #(
        .MAX_RULES (MAX_RULES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sorted_type_qualifier_filter_core: random and directed
// add/test/clear requests, with expected responses computed alongside.
// Depends on stqf_pkg and the core RTL.
module tb_top;
    import stqf_pkg::*;

    localparam int RULE_DEPTH = 64;
    // Opcode 3 is reserved: the core answers it with keep 0, status ok.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 430;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 200;

    // Expected response, kept with the request that caused it.
    typedef struct {
        req_t src;
        rsp_t want;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the rule table, sorted ascending by {type, qualifier}.
    logic [23:0] rule_keys [RULE_DEPTH];
    int rule_total = 0;

    req_t pending_reqs [$];
    answer_t answers [$];
    answer_t oldest;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic rsp_hold = 1'b0;
    int accepted_reqs = 0;
    int queued_total = 0;
    int error_count = 0;

    sorted_type_qualifier_filter_core #(
        .MAX_RULES(RULE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Apply one request to the shadow table and return the response it must
    // produce. The lower bound is the first stored key not below the request key.
    function automatic rsp_t apply_rule_op(input req_t r);
        logic [23:0] key;
        int pos;
        int idx;
        logic listed;
        rsp_t res;
        key = {r.type_code, r.qualifier};
        res = '0;
        pos = 0;
        while (pos < rule_total && rule_keys[pos] < key)
            pos++;
        case (r.opcode)
            OP_ADD:
            begin
                // Bad type first, then duplicate, then full.
                if (r.type_code == 8'd0)
                    res.status = ST_BADTYPE;
                else if (pos < rule_total && rule_keys[pos] == key)
                    res.status = ST_PRESENT;
                else if (rule_total >= RULE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (idx = rule_total; idx > pos; idx--)
                        rule_keys[idx] = rule_keys[idx - 1];
                    rule_keys[pos] = key;
                    rule_total++;
                    res.status = ST_OK;
                end
            end
            OP_TEST:
            begin
                if (pos < rule_total && rule_keys[pos] == key)
                    res.keep = 1'b1;
                else
                begin
                    // Same type with another qualifier sits right next to pos.
                    listed = 1'b0;
                    if (pos > 0 && rule_keys[pos - 1][23:16] == r.type_code)
                        listed = 1'b1;
                    if (pos < rule_total && rule_keys[pos][23:16] == r.type_code)
                        listed = 1'b1;
                    res.keep = !listed;
                end
            end
            OP_CLEAR:
                rule_total = 0;
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [7:0] ty,
                            input logic [15:0] qu);
        req_t r;
        r.opcode = op;
        r.type_code = ty;
        r.qualifier = qu;
        pending_reqs.push_back(r);
        queued_total++;
    endtask

    // Poll on the falling edge so the driver and monitor have settled.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || answers.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: predict on acceptance, then advance to the next pending
    // request or go idle. Hold the payload while the core stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                answers.push_back('{req, apply_rule_op(req)});
                accepted_reqs++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response side back-pressure: random stalls plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Response monitor: compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers.size() == 0)
                report_mismatch($sformatf("response keep %0b status %0d with none pending",
                                          rsp.keep, rsp.status));
            else
            begin
                oldest = answers.pop_front();
                if (rsp.keep !== oldest.want.keep)
                    report_mismatch($sformatf("op %0d type %0d qual %0d: keep %b, want %b",
                                              oldest.src.opcode, oldest.src.type_code,
                                              oldest.src.qualifier, rsp.keep,
                                              oldest.want.keep));
                if (rsp.status !== oldest.want.status)
                    report_mismatch($sformatf("op %0d type %0d qual %0d: status %0d, want %0d",
                                              oldest.src.opcode, oldest.src.type_code,
                                              oldest.src.qualifier, rsp.status,
                                              oldest.want.status));
            end
        end
    end

    // Long hold-off: once traffic is flowing, block responses for a stretch so
    // the core backs up and stalls its request side while requests keep coming.
    initial
    begin
        wait (accepted_reqs >= 60);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Stimulus: directed corners first, then four idling phases of random
    // sessions. Each session draws rules from a small pool of types so the
    // table fills, hits duplicates and overflows before it is cleared.
    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        int phase;
        int step;
        int ops;
        int roll;
        int pool_n;
        logic narrow;
        logic [15:0] qual_base;
        logic [7:0] type_pool [4];
        logic [23:0] added [$];
        logic [23:0] pick;
        logic [7:0] ty;
        logic [15:0] qu;

        send_pct = '{0, 60, 0, 32};
        recv_pct = '{0, 0, 60, 32};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, bad types, field extremes, duplicates,
        // blocked and unlisted types, reserved opcode, clear.
        push_req(OP_TEST, 8'd255, 16'hFFFF);
        push_req(OP_ADD, 8'd0, 16'h0000);
        push_req(OP_ADD, 8'd0, 16'hFFFF);
        push_req(OP_ADD, 8'd1, 16'h0000);
        push_req(OP_ADD, 8'd255, 16'hFFFF);
        push_req(OP_ADD, 8'd1, 16'h0000);
        push_req(OP_ADD, 8'd128, 16'h8000);
        push_req(OP_ADD, 8'd128, 16'h0001);
        push_req(OP_TEST, 8'd1, 16'h0000);
        push_req(OP_TEST, 8'd1, 16'h0001);
        push_req(OP_TEST, 8'd255, 16'hFFFE);
        push_req(OP_TEST, 8'd128, 16'h8000);
        push_req(OP_TEST, 8'd128, 16'h4000);
        push_req(OP_TEST, 8'd2, 16'h0000);
        push_req(OP_TEST, 8'd0, 16'h0000);
        push_req(OP_UNUSED, 8'd1, 16'h0001);
        push_req(OP_UNUSED, 8'd255, 16'hFFFF);
        push_req(OP_ADD, 8'h55, 16'hAAAA);
        push_req(OP_ADD, 8'hAA, 16'h5555);
        push_req(OP_TEST, 8'hAA, 16'h5555);
        push_req(OP_CLEAR, 8'd0, 16'h0000);
        push_req(OP_TEST, 8'd1, 16'h0001);
        push_req(OP_CLEAR, 8'hFF, 16'hFFFF);
        push_req(OP_ADD, 8'd1, 16'h0000);
        // Pause the sender until every directed response is back.
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            queued_total = 0;
            while (queued_total < PHASE_ITEMS)
            begin
                pool_n = $urandom_range(1, 4);
                narrow = ($urandom_range(3) != 0);
                qual_base = 16'($urandom);
                for (step = 0; step < 4; step++)
                    type_pool[step] = 8'($urandom_range(1, 255));
                if ($urandom_range(7) == 0)
                    type_pool[0] = 8'd1;
                if ($urandom_range(7) == 0)
                    type_pool[pool_n - 1] = 8'd255;
                added.delete();
                ops = $urandom_range(30, 160);
                for (step = 0; step < ops; step++)
                begin
                    roll = $urandom_range(99);
                    ty = type_pool[$urandom_range(pool_n - 1)];
                    // Narrow qualifier windows give duplicates and fill the table.
                    qu = narrow ? qual_base + 16'($urandom_range(47)) : 16'($urandom);
                    if (roll < 55)
                    begin
                        if (roll < 2)
                            ty = 8'd0;
                        push_req(OP_ADD, ty, qu);
                        added.push_back({ty, qu});
                    end
                    else if (roll < 88)
                    begin
                        // Mix exact hits, pool types and random types.
                        if (roll < 70 && added.size() != 0)
                        begin
                            pick = added[$urandom_range(added.size() - 1)];
                            push_req(OP_TEST, pick[23:16], pick[15:0]);
                        end
                        else if (roll < 80)
                            push_req(OP_TEST, ty, qu);
                        else
                            push_req(OP_TEST, 8'($urandom_range(255)), qu);
                    end
                    else if (roll < 92)
                        push_req(OP_UNUSED, 8'($urandom_range(255)), 16'($urandom));
                    else if (roll < 93)
                    begin
                        push_req(OP_CLEAR, 8'($urandom_range(255)), 16'($urandom));
                        added.delete();
                    end
                    else
                        push_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                                 16'($urandom));
                end
                if ($urandom_range(9) < 7)
                    push_req(OP_CLEAR, 8'($urandom_range(255)), 16'($urandom));
            end
            // Hold new requests until the phase has fully drained.
            wait_drained();
        end

        // Let any stray response show up before judging the run.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every add shifting a full table).
    initial
    begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
